@@ design/ptt_pkg.sv @@
// shared types, codes and constants for the periodic timer table
package ptt_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 32;
  localparam int unsigned MAX_FIRES      = 32;
  localparam int unsigned FIRE_CNT_W     = $clog2(MAX_FIRES + 1);

  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned REM_W    = 26;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(100);
  localparam logic [STEP_W-1:0]   TICK_STEP_RST  = STEP_W'(50);
  localparam logic [LEVEL_W-1:0]  FIRE_LEVEL_RST = LEVEL_W'(20);

  localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_TICK    = 2'd1,
    OP_VERDICT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PERIOD = 2'd0,
    CFG_TICK_STEP  = 2'd1,
    CFG_FIRE_LEVEL = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_FIRE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [REM_W-1:0] remaining;
    logic [PERIOD_W-1:0]     period;
  } slot_entry_t;

  typedef struct packed {
    kind_t             kind;
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

endpackage

@@ design/periodic_timer_table.sv @@
// periodic timer table: slot allocation, tick walk over a slot memory, fire reporting
//
//  channel  | signals                          | content
//  ---------+----------------------------------+---------------------------------------
//  in_      | tvalid tready tdata tuser        | op in tuser; period, slot, keep in tdata
//  out_     | tvalid tready tdata tuser tlast  | kind in tuser; grant, slot in tdata
//  cfg_     | we index wdata                   | min_period, tick_step, fire_level
//
// a verdict takes effect when accepted; a request's reply passes the holding register, then the output register.
// a tick walks the slot memory one slot per cycle unless the output channel stalls a fire
// result, then passes a flush state that marks the last held fire result with tlast.
// the walk is paced by the single read/write port pair of the slot memory.
// reset is synchronous; the slot memory needs no clearing since unused slots are ignored.
// one result is held back during a tick so the last fire can carry tlast.
module periodic_timer_table #(
  parameter int unsigned SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // period_ms [23:0], target_slot [28:24], keep_running [29], zero [31:30]
  input  logic [ptt_pkg::IN_DATA_W-1:0]    in_tdata,
  // op [1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // granted [0], slot_number [5:1], zero [7:6]
  output logic [ptt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // reply_kind [0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ptt_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PERIOD_W-1:0]     min_period_r;
  logic [STEP_W-1:0]       tick_step_r;
  logic [LEVEL_W-1:0]      fire_level_r;
  logic [SLOT_COUNT-1:0]   used_r, used_nxt;

  slot_entry_t             slot_mem [SLOT_COUNT];
  slot_entry_t             mem_q_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  slot_entry_t             mem_wdata;
  logic [IDX_W-1:0]        rd_addr;

  logic [CNT_W-1:0]        walk_idx_r, walk_idx_nxt;
  logic                    calc_valid_r, calc_valid_nxt;
  logic [IDX_W-1:0]        calc_idx_r, calc_idx_nxt;
  logic [FIRE_CNT_W-1:0]   fire_cnt_r, fire_cnt_nxt;

  logic                    pend_valid_r, pend_valid_nxt;
  logic                    pend_ready_r, pend_ready_nxt;
  result_t                 pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  result_t                 out_r, out_nxt;

  logic                    in_acc;
  op_t                     in_op;
  logic [PERIOD_W-1:0]     in_period;
  logic [SLOT_W-1:0]       in_target;
  logic                    in_keep;
  logic                    out_free;
  logic                    out_load;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic                    grant;

  logic signed [REM_W:0]   r_sub;
  logic signed [REM_W-1:0] r_sat;
  logic signed [REM_W-1:0] r_new;
  logic                    calc_used;
  logic                    hit;
  logic                    report;
  logic                    stall;

  assign in_op     = op_t'(in_tuser);
  assign in_period = in_tdata[PERIOD_W-1:0];
  assign in_target = in_tdata[PERIOD_W +: SLOT_W];
  assign in_keep   = in_tdata[PERIOD_W + SLOT_W];
  assign in_tready = (state_r == ST_IDLE) && !pend_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - SLOT_W - 1){1'b0}}, out_r.slot, out_r.granted};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_free   = !out_valid_r || out_tready;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign grant = (in_period >= min_period_r) && free_found;

  // tick arithmetic on the slot read back from memory
  assign calc_used = used_r[calc_idx_r];
  assign r_sub = {mem_q_r.remaining[REM_W-1], mem_q_r.remaining}
               - $signed({{(REM_W + 1 - STEP_W){1'b0}}, tick_step_r});
  assign r_sat = (r_sub[REM_W] && !r_sub[REM_W-1]) ? REM_MIN : r_sub[REM_W-1:0];
  assign r_new = r_sat + $signed({{(REM_W - PERIOD_W){1'b0}}, mem_q_r.period});
  assign hit    = calc_valid_r && calc_used
               && (r_sat <= $signed({{(REM_W - LEVEL_W){1'b0}}, fire_level_r}));
  assign report = hit && (fire_cnt_r < FIRE_CNT_W'(MAX_FIRES));
  assign stall  = report && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    walk_idx_nxt   = walk_idx_r;
    calc_valid_nxt = calc_valid_r;
    calc_idx_nxt   = calc_idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = calc_idx_r;
    mem_wdata      = mem_q_r;
    rd_addr        = calc_idx_r;

    out_load = pend_valid_r && out_free
            && (pend_ready_r || ((state_r == ST_WALK) && report && !stall));

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    pend_valid_nxt = out_load ? 1'b0 : pend_valid_r;
    pend_ready_nxt = pend_ready_r;
    pend_nxt       = pend_r;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = '0;
        if (in_acc) begin
          case (in_op)
            OP_REQUEST: begin
              if (grant) begin
                used_nxt[free_idx] = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = free_idx;
                mem_wdata.remaining = $signed({{(REM_W - PERIOD_W){1'b0}}, in_period});
                mem_wdata.period    = in_period;
              end
              pend_valid_nxt = 1'b1;
              pend_ready_nxt = 1'b1;
              pend_nxt.kind    = KIND_REPLY;
              pend_nxt.granted = grant;
              pend_nxt.slot    = grant ? SLOT_W'(free_idx) : '0;
              pend_nxt.last    = 1'b0;
            end
            OP_TICK: begin
              calc_valid_nxt = 1'b1;
              calc_idx_nxt   = '0;
              walk_idx_nxt   = CNT_W'(1);
              fire_cnt_nxt   = '0;
              state_nxt      = ST_WALK;
            end
            OP_VERDICT: begin
              if (!in_keep) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (int'(in_target) == i) used_nxt[i] = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (calc_valid_r && calc_used) begin
            mem_we    = 1'b1;
            mem_waddr = calc_idx_r;
            mem_wdata.remaining = hit ? r_new : r_sat;
            mem_wdata.period    = mem_q_r.period;
          end
          if (report) begin
            pend_valid_nxt   = 1'b1;
            pend_ready_nxt   = 1'b0;
            pend_nxt.kind    = KIND_FIRE;
            pend_nxt.granted = 1'b0;
            pend_nxt.slot    = SLOT_W'(calc_idx_r);
            pend_nxt.last    = 1'b0;
            fire_cnt_nxt     = fire_cnt_r + FIRE_CNT_W'(1);
          end
          if (walk_idx_r < CNT_W'(SLOT_COUNT)) begin
            rd_addr        = walk_idx_r[IDX_W-1:0];
            calc_idx_nxt   = walk_idx_r[IDX_W-1:0];
            calc_valid_nxt = 1'b1;
            walk_idx_nxt   = walk_idx_r + CNT_W'(1);
          end else begin
            calc_valid_nxt = 1'b0;
            state_nxt      = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r) begin
          pend_ready_nxt = 1'b1;
          pend_nxt.last  = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MIN_PERIOD_RST;
      tick_step_r  <= TICK_STEP_RST;
      fire_level_r <= FIRE_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PERIOD: min_period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_TICK_STEP:  tick_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_FIRE_LEVEL: fire_level_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      calc_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      walk_idx_r   <= '0;
      fire_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      calc_valid_r <= calc_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_ready_r <= pend_ready_nxt;
      out_valid_r  <= out_valid_nxt;
      walk_idx_r   <= walk_idx_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    calc_idx_r <= calc_idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

endmodule

@@ dv/tb_periodic_timer_table.sv @@
// self-checking testbench for the periodic timer table: directed rows, random phases, saturation
module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int NSLOT = SLOT_COUNT_DEF;
  localparam int SETTLE = NSLOT + 8;
  localparam int STALL_LIMIT = 3000;
  localparam longint LEFT_MIN = -64'sd33554432;
  localparam longint LEFT_MAX = 64'sd33554431;
  localparam int DIR_N = 23;

  typedef struct packed {
    op_t               op;
    logic [PERIOD_W-1:0] period;
    logic [SLOT_W-1:0] slot;
    logic              keep;
    logic              typed;
    result_t           want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [PERIOD_W-1:0]     min_period_q;
  logic [STEP_W-1:0]       tick_step_q;
  logic [LEVEL_W-1:0]      fire_level_q;
  logic                    slot_busy [NSLOT];
  logic signed [REM_W-1:0] slot_left [NSLOT];
  logic [PERIOD_W-1:0]     slot_reload [NSLOT];

  result_t           due_results [$];
  logic [SLOT_W-1:0] fired_slots [$];
  int                errors = 0;
  int                idle_cycles = 0;
  bit                quiet = 1'b0;

  row_t dir_rows [DIR_N] = '{
    '{OP_REQUEST, 24'd99,       5'd0,  1'b0, 1'b1, '{KIND_REPLY, 1'b0, 5'd0, 1'b0}},
    '{OP_REQUEST, 24'd100,      5'd0,  1'b0, 1'b1, '{KIND_REPLY, 1'b1, 5'd0, 1'b0}},
    '{OP_REQUEST, 24'hFFFFFF,   5'd31, 1'b1, 1'b1, '{KIND_REPLY, 1'b1, 5'd1, 1'b0}},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_TICK,    24'hFFFFFF,   5'd31, 1'b1, 1'b0, '0},
    '{OP_VERDICT, 24'd0,        5'd0,  1'b1, 1'b0, '0},
    '{OP_VERDICT, 24'd0,        5'd31, 1'b0, 1'b0, '0},
    '{OP_NONE,    24'hFFFFFF,   5'd31, 1'b1, 1'b0, '0},
    '{OP_VERDICT, 24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_REQUEST, 24'd200,      5'd0,  1'b0, 1'b1, '{KIND_REPLY, 1'b1, 5'd0, 1'b0}},
    '{OP_REQUEST, 24'd0,        5'd0,  1'b0, 1'b1, '{KIND_REPLY, 1'b0, 5'd0, 1'b0}},
    '{OP_REQUEST, 24'd150,      5'd0,  1'b0, 1'b1, '{KIND_REPLY, 1'b1, 5'd2, 1'b0}},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_TICK,    24'd0,        5'd0,  1'b0, 1'b0, '0},
    '{OP_VERDICT, 24'd0,        5'd1,  1'b0, 1'b0, '0},
    '{OP_REQUEST, 24'h800000,   5'd0,  1'b0, 1'b1, '{KIND_REPLY, 1'b1, 5'd1, 1'b0}},
    '{OP_VERDICT, 24'd0,        5'd1,  1'b0, 1'b0, '0},
    '{OP_VERDICT, 24'd0,        5'd2,  1'b0, 1'b0, '0},
    '{OP_VERDICT, 24'd0,        5'd0,  1'b0, 1'b0, '0}
  };

  periodic_timer_table #(.SLOT_COUNT(NSLOT)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_left(longint v);
    if (v < LEFT_MIN) return LEFT_MIN;
    if (v > LEFT_MAX) return LEFT_MAX;
    return v;
  endfunction

  function automatic void advance_table(op_t op, logic [PERIOD_W-1:0] period,
                                        logic [SLOT_W-1:0] target, logic keep);
    longint  r;
    int      n;
    bit      done;
    bit      have_held;
    result_t res;
    result_t held;
    n = 0;
    done = 1'b0;
    have_held = 1'b0;
    held = '0;
    res = '{kind: KIND_REPLY, granted: 1'b0, slot: '0, last: 1'b0};
    case (op)
      OP_REQUEST: begin
        if (period >= min_period_q) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!done && !slot_busy[i]) begin
              done = 1'b1;
              slot_busy[i] = 1'b1;
              slot_left[i] = REM_W'(period);
              slot_reload[i] = period;
              res.granted = 1'b1;
              res.slot = SLOT_W'(i);
            end
          end
        end
        due_results.push_back(res);
      end
      OP_TICK: begin
        fired_slots.delete();
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_busy[i]) begin
            r = clamp_left(longint'(slot_left[i]) - longint'(tick_step_q));
            if (r <= longint'(fire_level_q)) begin
              r = clamp_left(r + longint'(slot_reload[i]));
              fired_slots.push_back(SLOT_W'(i));
              if (n < MAX_FIRES) begin
                if (have_held) due_results.push_back(held);
                held = '{kind: KIND_FIRE, granted: 1'b0, slot: SLOT_W'(i), last: 1'b0};
                have_held = 1'b1;
                n++;
              end
            end
            slot_left[i] = r[REM_W-1:0];
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          due_results.push_back(held);
        end
      end
      OP_VERDICT: begin
        if (!keep && target < NSLOT) slot_busy[target] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(op_t op, logic [PERIOD_W-1:0] period, logic [SLOT_W-1:0] target,
                           logic keep);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, keep, target, period};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    advance_table(op, period, target, keep);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_MIN_PERIOD: min_period_q = value;
      CFG_TICK_STEP:  tick_step_q = value[STEP_W-1:0];
      CFG_FIRE_LEVEL: fire_level_q = value[LEVEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every result is out, then let a tick walk finish
  task automatic drain_table();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic release_all();
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_busy[i]) send_item(OP_VERDICT, 24'($urandom), SLOT_W'(i), 1'b0);
    end
  endtask

  task automatic random_item();
    int                  pick;
    int                  sel;
    longint              span;
    logic [PERIOD_W-1:0] per;
    logic [SLOT_W-1:0]   tgt;
    logic                keep;
    per = 24'($urandom);
    tgt = 5'($urandom);
    keep = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      sel = $urandom_range(0, 9);
      span = longint'(min_period_q) + longint'($urandom_range(0, 6 * tick_step_q));
      if (sel == 1) begin
        per = (min_period_q == 0) ? 24'd0 : 24'($urandom_range(0, min_period_q - 1));
      end else if (sel != 0) begin
        per = (span > 64'hFFFFFF) ? 24'hFFFFFF : span[PERIOD_W-1:0];
      end
      send_item(OP_REQUEST, per, tgt, keep);
    end else if (pick < 62) begin
      send_item(OP_TICK, per, tgt, keep);
    end else if (pick < 82 && fired_slots.size() > 0) begin
      // verdict on a slot that fired in the last tick
      sel = $urandom_range(0, fired_slots.size() - 1);
      tgt = fired_slots[sel];
      fired_slots.delete(sel);
      keep = ($urandom_range(0, 2) == 0);
      send_item(OP_VERDICT, per, tgt, keep);
    end else if (pick < 94) begin
      send_item(OP_VERDICT, per, tgt, keep);
    end else begin
      send_item(OP_NONE, per, tgt, keep);
    end
  endtask

  // result receiver with random backpressure
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin : check_out
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d granted %0d slot %0d last %0d",
                 $time, out_tuser, out_tdata[0], out_tdata[5:1], out_tlast);
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.kind || out_tdata[0] !== want.granted ||
            out_tdata[5:1] !== want.slot || out_tlast !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected kind %0d granted %0d slot %0d last %0d, got kind %0d granted %0d slot %0d last %0d",
                   $time, want.kind, want.granted, want.slot, want.last,
                   out_tuser, out_tdata[0], out_tdata[5:1], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("** periodic_timer_table: FAILED **");
    $finish;
  end

  initial begin
    logic [PERIOD_W-1:0] mp;
    logic [STEP_W-1:0]   st;
    logic [LEVEL_W-1:0]  lv;
    logic [7:0]          hi;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_REQUEST;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_PERIOD;
    cfg_wdata = '0;
    min_period_q = MIN_PERIOD_RST;
    tick_step_q = TICK_STEP_RST;
    fire_level_q = FIRE_LEVEL_RST;
    for (int i = 0; i < NSLOT; i++) begin
      slot_busy[i] = 1'b0;
      slot_left[i] = '0;
      slot_reload[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows at reset settings
    for (int k = 0; k < DIR_N; k++) begin
      send_item(dir_rows[k].op, dir_rows[k].period, dir_rows[k].slot, dir_rows[k].keep);
      if (dir_rows[k].typed) begin
        void'(due_results.pop_back());
        due_results.push_back(dir_rows[k].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_table();
      quiet = (ph == 1 || ph == 5);
      hi = 8'h00;
      case (ph)
        0: begin
          mp = 24'd100; st = 16'd50; lv = 16'd20;
        end
        1: begin
          mp = 24'd0; st = 16'd1; lv = 16'd0;
        end
        2: begin
          mp = 24'hFFFFFF; st = 16'hFFFF; lv = 16'hFFFF;
        end
        3: begin
          mp = 24'($urandom_range(0, 500));
          st = 16'($urandom_range(1, 300));
          lv = 16'($urandom_range(0, 600));
        end
        4: begin
          mp = 24'($urandom_range(0, 200000));
          st = 16'($urandom_range(1, 65535));
          lv = 16'($urandom);
          hi = 8'($urandom);
        end
        default: begin
          mp = 24'd30; st = 16'd30; lv = 16'd30;
        end
      endcase
      write_reg(CFG_MIN_PERIOD, mp);
      write_reg(CFG_TICK_STEP, {hi, st});
      write_reg(CFG_FIRE_LEVEL, {hi, lv});
      release_all();
      repeat (80) random_item();
    end

    // full table, refused request, every slot firing each tick, remaining saturating low
    drain_table();
    quiet = 1'b1;
    write_reg(CFG_MIN_PERIOD, 24'd0);
    write_reg(CFG_TICK_STEP, 24'h00FFFF);
    write_reg(CFG_FIRE_LEVEL, 24'h00FFFF);
    release_all();
    repeat (NSLOT + 1) send_item(OP_REQUEST, 24'($urandom_range(0, 200)), 5'($urandom), 1'b0);
    repeat (520) send_item(OP_TICK, 24'($urandom), 5'($urandom), 1'($urandom));
    release_all();
    quiet = 1'b0;

    drain_table();
    if (errors == 0) begin
      $display("** periodic_timer_table: PASSED **");
    end else begin
      $display("** periodic_timer_table: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ptt_pkg.sv
design/periodic_timer_table.sv
dv/tb_periodic_timer_table.sv
